/* hdl/secs_pkg.sv */
// Shared types, codes and helpers for the SPI EEPROM command sequencer.
`timescale 1ns / 1ps

package secs_pkg;

   // Request codes carried on req_tuser
   localparam logic [3:0] CmdRdByte    = 4'd0;
   localparam logic [3:0] CmdRdWord    = 4'd1;
   localparam logic [3:0] CmdWrByte    = 4'd2;
   localparam logic [3:0] CmdWrWord    = 4'd3;
   localparam logic [3:0] CmdUpdByte   = 4'd4;
   localparam logic [3:0] CmdUpdWord   = 4'd5;
   localparam logic [3:0] CmdIsReady   = 4'd6;
   localparam logic [3:0] CmdWaitReady = 4'd7;
   localparam logic [3:0] CmdSpiRx     = 4'd8;

   // Action codes carried on rsp_tuser
   localparam logic [1:0] ActCsLow  = 2'd0;
   localparam logic [1:0] ActSend   = 2'd1;
   localparam logic [1:0] ActCsHigh = 2'd2;
   localparam logic [1:0] ActDone   = 2'd3;

   // 25xx instruction bytes
   localparam logic [7:0] OpcWrsr  = 8'h01;
   localparam logic [7:0] OpcWrite = 8'h02;
   localparam logic [7:0] OpcRead  = 8'h03;
   localparam logic [7:0] OpcRdsr  = 8'h05;
   localparam logic [7:0] OpcWren  = 8'h06;
   localparam logic [7:0] DummyByte = 8'h00;

   localparam logic [15:0] PollLimitReset = 16'd400;

   // Result list: four beats deep; one request beat yields at most three
   localparam int MaxResults = 4;

   // Register file decode (word index from paddr[2])
   localparam logic RegBusyPollLimit = 1'b0;

   typedef struct packed {
      logic [3:0]  command;
      logic [15:0] address;
      logic [15:0] value;
      logic [7:0]  rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] tx_byte;
   } res_entry_type;

   typedef struct packed {
      logic [2:0]                     count;
      res_entry_type [MaxResults-1:0] entry;
      logic [15:0]                    read_data;
      logic                           ready_res;
      logic                           timeout;
   } res_list_type;

   // Append one action beat to a result list
   function automatic res_list_type push(res_list_type l, logic [1:0] act, logic [7:0] tx);
      res_list_type r;
      r = l;
      r.entry[l.count[1:0]] = '{action: act, tx_byte: tx};
      r.count = l.count + 3'd1;
      return r;
   endfunction

endpackage

/* hdl/secs_engine.sv */
// Sequencer state and next-state logic: one request or rx beat in, a result list out.
`timescale 1ns / 1ps

module secs_engine #(
   parameter int unsigned ADDRESS_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  secs_pkg::req_item_type item,
   input  logic [15:0]           busy_poll_limit,
   output secs_pkg::res_list_type results
);

   localparam int unsigned AddrBytes = (ADDRESS_BITS + 7) / 8;
   localparam int unsigned AddrWide  = AddrBytes * 8;

   localparam logic [2:0] OpRdWord   = 3'(secs_pkg::CmdRdWord);
   localparam logic [2:0] OpWrByte   = 3'(secs_pkg::CmdWrByte);
   localparam logic [2:0] OpWrWord   = 3'(secs_pkg::CmdWrWord);
   localparam logic [2:0] OpUpdByte  = 3'(secs_pkg::CmdUpdByte);
   localparam logic [2:0] OpUpdWord  = 3'(secs_pkg::CmdUpdWord);
   localparam logic [2:0] OpIsReady  = 3'(secs_pkg::CmdIsReady);

   typedef enum logic [3:0] {
      PhIdle,
      PhWrenCmd,
      PhWrCmd,
      PhWrAddr,
      PhWrData,
      PhRdCmd,
      PhRdAddr,
      PhRdData,
      PhPollCmd,
      PhPollData
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [2:0]              op_ff, op_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [15:0]             val_ff, val_in;
   logic [15:0]             rw_ff, rw_in;
   logic [15:0]             pc_ff, pc_in;
   logic                    bs_ff, bs_in;
   logic [1:0]              fp_ff, fp_in;
   logic                    to_ff, to_in;
   logic                    rdy_ff, rdy_in;

   // Address byte selection, MSB first
   logic [ADDRESS_BITS-1:0] cur_addr;
   logic [AddrWide-1:0]     cur_wide;
   logic [1:0]              fp_inc;
   logic [1:0]              addr_k;
   logic [1:0]              sh_idx;
   logic [7:0]              addr_byte;
   logic [7:0]              data_byte;

   always_comb begin
      cur_addr  = addr_ff + ADDRESS_BITS'(bs_ff);
      cur_wide  = AddrWide'(cur_addr);
      fp_inc    = fp_ff + 2'd1;
      addr_k    = (phase_ff == PhWrAddr || phase_ff == PhRdAddr) ? fp_inc : 2'd0;
      sh_idx    = 2'(AddrBytes - 1) - addr_k;
      addr_byte = 8'(cur_wide >> {sh_idx, 3'b000});
      data_byte = bs_ff ? val_ff[15:8] : val_ff[7:0];
   end

   // Next-state and result list
   logic       go_start_poll, go_after_read, go_after_poll, go_update;
   logic       go_start_read, go_start_write, go_poll_frame, go_finish;
   logic [1:0] upd_from;
   logic       is_word, is_upd, is_wr, last_sel;
   secs_pkg::res_list_type lst;

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      addr_in  = addr_ff;
      val_in   = val_ff;
      rw_in    = rw_ff;
      pc_in    = pc_ff;
      bs_in    = bs_ff;
      fp_in    = fp_ff;
      to_in    = to_ff;
      rdy_in   = rdy_ff;
      lst      = '0;
      go_start_poll  = 1'b0;
      go_after_read  = 1'b0;
      go_after_poll  = 1'b0;
      go_update      = 1'b0;
      go_start_read  = 1'b0;
      go_start_write = 1'b0;
      go_poll_frame  = 1'b0;
      go_finish      = 1'b0;
      upd_from       = 2'd0;

      if (item_valid) begin
         if (item.command == secs_pkg::CmdSpiRx) begin
            // Returned SPI byte advances the frame
            unique case (phase_ff)
               PhIdle: begin
               end
               PhWrenCmd: begin
                  lst = secs_pkg::push(lst, secs_pkg::ActCsHigh, 8'h00);
                  lst = secs_pkg::push(lst, secs_pkg::ActCsLow, 8'h00);
                  lst = secs_pkg::push(lst, secs_pkg::ActSend, secs_pkg::OpcWrite);
                  phase_in = PhWrCmd;
               end
               PhWrCmd, PhRdCmd: begin
                  fp_in = 2'd0;
                  lst = secs_pkg::push(lst, secs_pkg::ActSend, addr_byte);
                  phase_in = (phase_ff == PhWrCmd) ? PhWrAddr : PhRdAddr;
               end
               PhWrAddr, PhRdAddr: begin
                  fp_in = fp_inc;
                  if (32'(fp_inc) < AddrBytes) begin
                     lst = secs_pkg::push(lst, secs_pkg::ActSend, addr_byte);
                  end else if (phase_ff == PhWrAddr) begin
                     lst = secs_pkg::push(lst, secs_pkg::ActSend, data_byte);
                     phase_in = PhWrData;
                  end else begin
                     lst = secs_pkg::push(lst, secs_pkg::ActSend, secs_pkg::DummyByte);
                     phase_in = PhRdData;
                  end
               end
               PhWrData: begin
                  lst = secs_pkg::push(lst, secs_pkg::ActCsHigh, 8'h00);
                  go_start_poll = 1'b1;
               end
               PhRdData: begin
                  if (bs_ff) begin
                     rw_in[15:8] = item.rx_byte;
                  end else begin
                     rw_in[7:0] = item.rx_byte;
                  end
                  lst = secs_pkg::push(lst, secs_pkg::ActCsHigh, 8'h00);
                  go_after_read = 1'b1;
               end
               PhPollCmd: begin
                  lst = secs_pkg::push(lst, secs_pkg::ActSend, secs_pkg::DummyByte);
                  phase_in = PhPollData;
               end
               PhPollData: begin
                  lst = secs_pkg::push(lst, secs_pkg::ActCsHigh, 8'h00);
                  rdy_in = ~item.rx_byte[0];
                  if (op_ff == OpIsReady) begin
                     go_finish = 1'b1;
                  end else begin
                     pc_in = pc_ff + 16'd1;
                     if (rdy_in) begin
                        go_after_poll = 1'b1;
                     end else if (pc_in >= busy_poll_limit) begin
                        to_in = 1'b1;
                        go_after_poll = 1'b1;
                     end else begin
                        go_poll_frame = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end else if (item.command <= secs_pkg::CmdWaitReady && phase_ff == PhIdle) begin
            // New host request
            op_in   = item.command[2:0];
            addr_in = ADDRESS_BITS'(item.address);
            val_in  = item.value;
            rw_in   = 16'd0;
            pc_in   = 16'd0;
            bs_in   = 1'b0;
            fp_in   = 2'd0;
            to_in   = 1'b0;
            rdy_in  = 1'b0;
            unique case (item.command)
               secs_pkg::CmdWrByte, secs_pkg::CmdWrWord: go_start_write = 1'b1;
               secs_pkg::CmdIsReady:                     go_poll_frame  = 1'b1;
               secs_pkg::CmdWaitReady:                   go_start_poll  = 1'b1;
               default:                                  go_start_read  = 1'b1;
            endcase
         end
      end

      is_word  = (op_in == OpRdWord) || (op_in == OpUpdWord);
      is_upd   = (op_in == OpUpdByte) || (op_in == OpUpdWord);
      is_wr    = (op_in == OpWrByte) || (op_in == OpWrWord);
      last_sel = (op_in == OpUpdWord);

      // Start of status polling; a zero limit times out at once
      if (go_start_poll) begin
         pc_in = 16'd0;
         if (busy_poll_limit == 16'd0) begin
            to_in = 1'b1;
            rdy_in = 1'b0;
            go_after_poll = 1'b1;
         end else begin
            go_poll_frame = 1'b1;
         end
      end

      // End of a read frame
      if (go_after_read) begin
         if (is_word && !bs_in) begin
            bs_in = 1'b1;
            go_start_read = 1'b1;
         end else if (is_upd) begin
            go_update = 1'b1;
            upd_from = 2'd0;
         end else begin
            go_finish = 1'b1;
         end
      end

      // End of status polling after a write, an update write or a wait request
      if (go_after_poll) begin
         if (is_wr) begin
            if (op_in == OpWrWord && !bs_in) begin
               bs_in = 1'b1;
               go_start_write = 1'b1;
            end else begin
               go_finish = 1'b1;
            end
         end else if (is_upd) begin
            go_update = 1'b1;
            upd_from = {1'b0, bs_in} + 2'd1;
         end else begin
            go_finish = 1'b1;
         end
      end

      // Update: write the next byte that differs
      if (go_update) begin
         if (upd_from == 2'd0 && rw_in[7:0] != val_in[7:0]) begin
            bs_in = 1'b0;
            go_start_write = 1'b1;
         end else if (upd_from <= 2'd1 && last_sel && rw_in[15:8] != val_in[15:8]) begin
            bs_in = 1'b1;
            go_start_write = 1'b1;
         end else begin
            go_finish = 1'b1;
         end
      end

      // Frame starts and completion
      if (go_start_read) begin
         lst = secs_pkg::push(lst, secs_pkg::ActCsLow, 8'h00);
         lst = secs_pkg::push(lst, secs_pkg::ActSend, secs_pkg::OpcRead);
         phase_in = PhRdCmd;
      end
      if (go_start_write) begin
         lst = secs_pkg::push(lst, secs_pkg::ActCsLow, 8'h00);
         lst = secs_pkg::push(lst, secs_pkg::ActSend, secs_pkg::OpcWren);
         phase_in = PhWrenCmd;
      end
      if (go_poll_frame) begin
         lst = secs_pkg::push(lst, secs_pkg::ActCsLow, 8'h00);
         lst = secs_pkg::push(lst, secs_pkg::ActSend, secs_pkg::OpcRdsr);
         phase_in = PhPollCmd;
      end
      if (go_finish) begin
         lst = secs_pkg::push(lst, secs_pkg::ActDone, 8'h00);
         phase_in = PhIdle;
      end

      lst.read_data = rw_in;
      lst.ready_res = rdy_in;
      lst.timeout   = to_in;
      results       = lst;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhIdle;
         op_ff    <= 3'd0;
         addr_ff  <= '0;
         val_ff   <= 16'd0;
         rw_ff    <= 16'd0;
         pc_ff    <= 16'd0;
         bs_ff    <= 1'b0;
         fp_ff    <= 2'd0;
         to_ff    <= 1'b0;
         rdy_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         addr_ff  <= addr_in;
         val_ff   <= val_in;
         rw_ff    <= rw_in;
         pc_ff    <= pc_in;
         bs_ff    <= bs_in;
         fp_ff    <= fp_in;
         to_ff    <= to_in;
         rdy_ff   <= rdy_in;
      end
   end

endmodule

/* hdl/spi_eeprom_command_sequencer.sv */
// Top level of the SPI EEPROM command sequencer: ports, input stage, result list, CSR.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tuser: command; tdata: address, value, rx_byte
//  rsp     | out | rsp_tvalid/rsp_tready | tuser: action; tdata: tx_byte, read_data,
//          |     |                       |   ready_res, timeout; tlast: last of a beat's run
//  csr     | in  | APB psel/penable      | busy_poll_limit at byte address 0
//
// A request beat reaches its first result beat through the input register, then the
// result list. Each request beat yields zero to three result beats, drained one per
// cycle from that list with rsp_tready high; a beat with at most one result sustains
// one beat per cycle likewise. Reset is synchronous and sets busy_poll_limit to 400.
// A stalled rsp side holds the list and, once the input register is full, req_tready.
`timescale 1ns / 1ps

module spi_eeprom_command_sequencer #(
   parameter int unsigned ADDRESS_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [15:0] address, [31:16] value, [39:32] rx_byte
   input  logic [3:0]  req_tuser,   // [3:0] command
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] tx_byte, [23:8] read_data, [24] ready_res,
                                    // [25] timeout, [31:26] zero
   output logic [1:0]  rsp_tuser,   // [1:0] action
   output logic        rsp_tlast,
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration register
   logic [15:0] poll_limit_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == secs_pkg::RegBusyPollLimit) ?
                       {16'd0, poll_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff <= secs_pkg::PollLimitReset;
      end else if (csr_wr && csr_paddr[2] == secs_pkg::RegBusyPollLimit) begin
         poll_limit_ff <= csr_pwdata[15:0];
      end
   end

   // Input register
   logic                   in_valid_ff, in_valid_in;
   secs_pkg::req_item_type in_item_ff, in_item_in;
   secs_pkg::res_list_type list_ff, list_in;
   secs_pkg::res_list_type eng_results;
   logic                   load_ok, fire, pop;

   assign pop     = rsp_tvalid & rsp_tready;
   assign load_ok = (list_ff.count == 3'd0) || (list_ff.count == 3'd1 && rsp_tready);
   assign fire    = in_valid_ff & load_ok;
   assign req_tready = ~in_valid_ff | load_ok;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_item_in  = '{command: req_tuser,
                         address: req_tdata[15:0],
                         value:   req_tdata[31:16],
                         rx_byte: req_tdata[39:32]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_item_ff <= in_item_in;
   end

   secs_engine #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (fire),
      .item            (in_item_ff),
      .busy_poll_limit (poll_limit_ff),
      .results         (eng_results)
   );

   // Result list: load a new list or shift out the head beat
   always_comb begin
      list_in = list_ff;
      if (fire) begin
         list_in = eng_results;
      end else if (pop) begin
         list_in.count = list_ff.count - 3'd1;
         for (int i = 0; i < secs_pkg::MaxResults - 1; i++) begin
            list_in.entry[i] = list_ff.entry[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_ff <= '0;
      end else begin
         list_ff <= list_in;
      end
   end

   // Output beat from the list head; done fields only on the done beat
   logic is_done;

   assign is_done    = (list_ff.entry[0].action == secs_pkg::ActDone);
   assign rsp_tvalid = (list_ff.count != 3'd0);
   assign rsp_tuser  = list_ff.entry[0].action;
   assign rsp_tlast  = (list_ff.count == 3'd1);
   assign rsp_tdata  = {6'd0,
                        is_done & list_ff.timeout,
                        is_done & list_ff.ready_res,
                        is_done ? list_ff.read_data : 16'd0,
                        list_ff.entry[0].tx_byte};

`ifndef SYNTHESIS
   // List never holds more beats than one request can cause
   a_list_bound: assert property (@(posedge clock) disable iff (reset)
      list_ff.count <= 3'(secs_pkg::MaxResults))
      else $error("result list overflow");

   // Done closes the run of beats
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && is_done |-> rsp_tlast)
      else $error("done beat not last");

   // Held item blocks intake while the list cannot take a new run
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !load_ok |-> !req_tready)
      else $error("intake while list busy");

   // Only send beats carry a byte
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != secs_pkg::ActSend |-> rsp_tdata[7:0] == 8'h00)
      else $error("tx byte on non-send beat");
`endif

endmodule
